/* rtl/assert_macros.svh */
// assertion macros shared by the scheduler rtl
// expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AM_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AM_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mlfq_pkg.sv */
// shared codes and field widths of the multilevel feedback task scheduler
// no dependencies
`default_nettype none
package mlfq_pkg;
    localparam int CMD_W    = 3;
    localparam int ID_W     = 6;
    localparam int PRIO_W   = 8;
    localparam int WAIT_W   = 32;
    localparam int STAT_W   = 2;
    localparam int SLICE_W  = 14;
    localparam int BASE_W   = 12;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 16;
    localparam int COND_W   = 3;

    localparam logic [SLICE_W-1:0] SLICE_MAX = 14'd16383;

    localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TERMINATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BLOCK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    localparam logic [COND_W-1:0] COND_FREE       = 3'd0;
    localparam logic [COND_W-1:0] COND_READY      = 3'd1;
    localparam logic [COND_W-1:0] COND_RUNNING    = 3'd2;
    localparam logic [COND_W-1:0] COND_BLOCKED    = 3'd3;
    localparam logic [COND_W-1:0] COND_TERMINATED = 3'd4;

    localparam logic CFG_SLICE_BASE = 1'b0;
    localparam logic CFG_RECLAIM    = 1'b1;
endpackage
`default_nettype wire

/* rtl/multilevel_feedback_task_scheduler.sv */
// multilevel feedback task scheduler: create searches for the lowest free id; terminate,
// block, unblock read the target entry back; tick runs a 32-step remainder unit, then one
// sweep of the task memory; schedule scans the ready sets, one ready-set column a cycle
// one item at a time: the next item is taken in the strobe cycle; busy stays low for
// items that answer at once; receiver cannot stall
// synchronous active-low reset clears control, in-use and ready bits, running task and ticks
`default_nettype none
`include "assert_macros.svh"
module multilevel_feedback_task_scheduler #(
    parameter int TASK_COUNT  = 64,
    parameter int LEVEL_COUNT = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mlfq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [mlfq_pkg::ID_W-1:0]      i_task_id,
    input  wire logic [mlfq_pkg::PRIO_W-1:0]    i_priority_req,
    input  wire logic [mlfq_pkg::WAIT_W-1:0]    i_wait_time,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [mlfq_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                o_done,
    output logic [mlfq_pkg::STAT_W-1:0]         o_status,
    output logic [mlfq_pkg::ID_W-1:0]           o_result_id,
    output logic                                o_result_valid,
    output logic                                o_reschedule
);
    import mlfq_pkg::*;

    localparam int IW = $clog2(TASK_COUNT);
    localparam int LW = $clog2(LEVEL_COUNT);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TGT    = 3'd1;  // check target entry read back
    localparam logic [2:0] S_CRSCAN = 3'd2;  // search lowest free id
    localparam logic [2:0] S_TRUN   = 3'd3;  // charge running slice
    localparam logic [2:0] S_TDIV   = 3'd4;  // tick count modulo reclaim period
    localparam logic [2:0] S_TSWEEP = 3'd5;  // wake and reclaim sweep
    localparam logic [2:0] S_SRUN   = 3'd6;  // requeue running task
    localparam logic [2:0] S_SSCAN  = 3'd7;  // pick next task

    typedef struct packed {
        logic [LW-1:0]      level;
        logic [SLICE_W-1:0] slice;
        logic [WAIT_W-1:0]  wake;
    } t_tdata;

    // task memories: condition and the rest, shared read address
    logic [COND_W-1:0] m_cond [TASK_COUNT];
    t_tdata            m_data [TASK_COUNT];
    logic [COND_W-1:0] r_cond_q;
    t_tdata            r_data_q;

    logic [IW-1:0]     rd_addr, wr_addr;
    logic              cond_we, data_we;
    logic [COND_W-1:0] cond_wd;
    t_tdata            data_wd;

    // control registers
    logic [2:0]            r_state, n_state;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [IW-1:0]         r_id, n_id;
    logic [LW-1:0]         r_lv, n_lv;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [BASE_W-1:0]     r_slice_base, n_slice_base;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic [TASK_COUNT-1:0] r_in_use, n_in_use;
    logic [TASK_COUNT-1:0] r_ready [LEVEL_COUNT];
    logic [TASK_COUNT-1:0] n_ready [LEVEL_COUNT];
    logic [IW-1:0]         r_run_id, n_run_id;
    logic                  r_run_v, n_run_v;
    logic [WAIT_W-1:0]     r_tick, n_tick;
    logic [IW:0]           r_cnt, n_cnt;
    logic [PERIOD_W-1:0]   r_rem, n_rem;
    logic [4:0]            r_bit, n_bit;
    logic                  r_reclaim, n_reclaim;
    logic                  r_resched, n_resched;
    logic [IW-1:0]         r_best_id, n_best_id;
    logic [LW-1:0]         r_best_lv, n_best_lv;
    logic                  r_best_v, n_best_v;

    // result register
    logic                  r_done, n_done;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [ID_W-1:0]       r_rid, n_rid;
    logic                  r_rvalid, n_rvalid;
    logic                  r_resch_o, n_resch_o;

    // full slice of a level, saturated
    function automatic logic [SLICE_W-1:0] f_slice(input logic [BASE_W-1:0] b,
                                                   input logic [LW-1:0] lv);
        logic [16:0] p;
        p = 17'(b) * (17'(LEVEL_COUNT) - 17'(lv));
        return (p > 17'(SLICE_MAX)) ? SLICE_MAX : p[SLICE_W-1:0];
    endfunction

    always_comb begin
        logic              id_ok;
        logic [IW-1:0]     tid;
        logic [IW-1:0]     idx;
        logic [LW-1:0]     lv;
        logic [SLICE_W-1:0] sl;
        logic              ok;
        logic              hit;
        logic [LW-1:0]     hlv;
        logic              upd;
        logic [IW-1:0]     bid;
        logic [LW-1:0]     blv;
        logic              bv;
        logic [16:0]       sh;
        logic [16:0]       rn;

        n_state      = r_state;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_lv         = r_lv;
        n_wait       = r_wait;
        n_slice_base = r_slice_base;
        n_period     = r_period;
        n_in_use     = r_in_use;
        n_ready      = r_ready;
        n_run_id     = r_run_id;
        n_run_v      = r_run_v;
        n_tick       = r_tick;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_reclaim    = r_reclaim;
        n_resched    = r_resched;
        n_best_id    = r_best_id;
        n_best_lv    = r_best_lv;
        n_best_v     = r_best_v;
        n_done       = 1'b0;
        n_status     = r_status;
        n_rid        = r_rid;
        n_rvalid     = r_rvalid;
        n_resch_o    = r_resch_o;

        rd_addr = r_run_id;
        wr_addr = r_id;
        cond_we = 1'b0;
        data_we = 1'b0;
        cond_wd = COND_FREE;
        data_wd = r_data_q;

        id_ok = 32'(i_task_id) < TASK_COUNT;
        tid   = IW'(i_task_id);
        idx   = r_cnt[IW-1:0];
        lv    = r_data_q.level;
        sl    = r_data_q.slice;
        ok    = 1'b0;
        hit   = 1'b0;
        hlv   = '0;
        upd   = 1'b0;
        bid   = r_best_id;
        blv   = r_best_lv;
        bv    = r_best_v;
        sh    = '0;
        rn    = '0;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SLICE_BASE) begin
                n_slice_base = i_cfg_data[BASE_W-1:0];
            end else begin
                n_period = i_cfg_data[PERIOD_W-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_command;
                    n_id      = tid;
                    n_wait    = i_wait_time;
                    n_lv      = (32'(i_priority_req) > LEVEL_COUNT - 1) ?
                                LW'(LEVEL_COUNT - 1) : LW'(i_priority_req);
                    n_resched = 1'b0;
                    n_cnt     = '0;
                    unique case (i_command) inside
                        CMD_CREATE: n_state = S_CRSCAN;
                        CMD_TERMINATE, CMD_BLOCK, CMD_UNBLOCK: begin
                            // bad targets answer at once, good ones read their entry
                            if (id_ok && r_in_use[tid]) begin
                                rd_addr = tid;
                                n_state = S_TGT;
                            end else begin
                                n_done    = 1'b1;
                                n_status  = ST_INVALID;
                                n_rid     = '0;
                                n_rvalid  = 1'b0;
                                n_resch_o = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            rd_addr = r_run_id;
                            n_state = S_TRUN;
                        end
                        CMD_SCHEDULE: begin
                            rd_addr = r_run_id;
                            n_state = S_SRUN;
                        end
                        default: begin
                            n_done    = 1'b1;
                            n_status  = ST_INVALID;
                            n_rid     = '0;
                            n_rvalid  = 1'b0;
                            n_resch_o = 1'b0;
                        end
                    endcase
                end
            end

            S_TGT: begin
                if (r_cmd == CMD_UNBLOCK) begin
                    ok = (r_cond_q == COND_BLOCKED);
                end else if (r_cmd == CMD_TERMINATE) begin
                    ok = (r_cond_q != COND_TERMINATED);
                end else begin
                    ok = (r_cond_q == COND_READY) || (r_cond_q == COND_RUNNING);
                end
                n_done    = 1'b1;
                n_rid     = '0;
                n_rvalid  = 1'b0;
                n_resch_o = 1'b0;
                n_status  = ok ? ST_DONE : ST_INVALID;
                n_state   = S_IDLE;
                if (ok) begin
                    cond_we = 1'b1;
                    wr_addr = r_id;
                    if (r_cmd == CMD_UNBLOCK) begin
                        cond_wd = COND_READY;
                        n_ready[lv][r_id] = 1'b1;
                    end else begin
                        if (r_cond_q == COND_READY) begin
                            n_ready[lv][r_id] = 1'b0;
                        end
                        // losing the running task asks for a schedule
                        if (r_run_v && (r_run_id == r_id)) begin
                            n_run_v   = 1'b0;
                            n_resch_o = 1'b1;
                        end
                        if (r_cmd == CMD_TERMINATE) begin
                            cond_wd = COND_TERMINATED;
                        end else begin
                            cond_wd      = COND_BLOCKED;
                            data_we      = 1'b1;
                            data_wd.wake = r_tick + r_wait;
                        end
                    end
                end
            end

            S_CRSCAN: begin
                if (!r_in_use[idx]) begin
                    cond_we       = 1'b1;
                    data_we       = 1'b1;
                    wr_addr       = idx;
                    cond_wd       = COND_READY;
                    data_wd.level = r_lv;
                    data_wd.slice = f_slice(r_slice_base, r_lv);
                    data_wd.wake  = '0;
                    n_in_use[idx] = 1'b1;
                    n_ready[r_lv][idx] = 1'b1;
                    n_done    = 1'b1;
                    n_status  = ST_DONE;
                    n_rid     = ID_W'(idx);
                    n_rvalid  = 1'b1;
                    n_resch_o = 1'b0;
                    n_state   = S_IDLE;
                end else if (idx == IW'(TASK_COUNT - 1)) begin
                    n_done    = 1'b1;
                    n_status  = ST_NO_ID;
                    n_rid     = '0;
                    n_rvalid  = 1'b0;
                    n_resch_o = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_TRUN: begin
                if (r_run_v && (r_cond_q == COND_RUNNING)) begin
                    sl            = (r_data_q.slice != '0) ? r_data_q.slice - 1'b1 : '0;
                    data_we       = 1'b1;
                    wr_addr       = r_run_id;
                    data_wd.slice = sl;
                    n_resched     = (sl == '0);
                end
                n_rem   = '0;
                n_bit   = 5'd31;
                n_state = S_TDIV;
            end

            S_TDIV: begin
                // restoring remainder, one bit of the tick count a cycle
                sh    = {r_rem, r_tick[r_bit]};
                rn    = (sh >= 17'(r_period)) ? sh - 17'(r_period) : sh;
                n_rem = rn[PERIOD_W-1:0];
                if (r_bit == 5'd0) begin
                    n_reclaim = (r_period != '0) && (rn == '0);
                    n_cnt     = '0;
                    n_state   = S_TSWEEP;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end

            S_TSWEEP: begin
                // read entry cnt while handling entry cnt-1
                rd_addr = r_cnt[IW-1:0];
                if (r_cnt != '0) begin
                    idx     = IW'(r_cnt - 1'b1);
                    wr_addr = idx;
                    if (r_in_use[idx]) begin
                        if ((r_cond_q == COND_BLOCKED) && (r_data_q.wake != '0) &&
                            (r_tick >= r_data_q.wake)) begin
                            cond_we = 1'b1;
                            cond_wd = COND_READY;
                            n_ready[lv][idx] = 1'b1;
                        end else if (r_reclaim && (r_cond_q == COND_TERMINATED)) begin
                            cond_we       = 1'b1;
                            cond_wd       = COND_FREE;
                            n_in_use[idx] = 1'b0;
                        end
                    end
                end
                if (r_cnt == (IW+1)'(TASK_COUNT)) begin
                    n_done    = 1'b1;
                    n_status  = ST_DONE;
                    n_rid     = '0;
                    n_rvalid  = 1'b0;
                    n_resch_o = r_resched;
                    n_state   = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_SRUN: begin
                if (r_run_v && (r_cond_q == COND_RUNNING)) begin
                    // spent slice: demote one level and refill
                    if (sl == '0) begin
                        if (32'(lv) < LEVEL_COUNT - 1) begin
                            lv = lv + 1'b1;
                        end
                        sl = f_slice(r_slice_base, lv);
                    end
                    cond_we       = 1'b1;
                    data_we       = 1'b1;
                    wr_addr       = r_run_id;
                    cond_wd       = COND_READY;
                    data_wd.level = lv;
                    data_wd.slice = sl;
                    n_ready[lv][r_run_id] = 1'b1;
                end
                n_run_v  = 1'b0;
                n_best_v = 1'b0;
                n_cnt    = '0;
                n_state  = S_SSCAN;
            end

            S_SSCAN: begin
                for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
                    if (r_ready[l][idx]) begin
                        hit = 1'b1;
                        hlv = LW'(l);
                    end
                end
                // ascending ids: strict compare keeps the lowest id of the best level
                upd = hit && (!r_best_v || (hlv < r_best_lv));
                bid = upd ? idx : r_best_id;
                blv = upd ? hlv : r_best_lv;
                bv  = r_best_v || hit;
                n_best_id = bid;
                n_best_lv = blv;
                n_best_v  = bv;
                if (idx == IW'(TASK_COUNT - 1)) begin
                    n_done    = 1'b1;
                    n_status  = ST_DONE;
                    n_resch_o = 1'b0;
                    n_rvalid  = bv;
                    n_rid     = bv ? ID_W'(bid) : '0;
                    if (bv) begin
                        n_ready[blv][bid] = 1'b0;
                        cond_we  = 1'b1;
                        wr_addr  = bid;
                        cond_wd  = COND_RUNNING;
                        n_run_id = bid;
                        n_run_v  = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // task memories, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (cond_we) begin
            m_cond[wr_addr] <= cond_wd;
        end
        if (data_we) begin
            m_data[wr_addr] <= data_wd;
        end
        r_cond_q <= m_cond[rd_addr];
        r_data_q <= m_data[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slice_base <= BASE_W'(10);
            r_period     <= PERIOD_W'(100);
            r_in_use     <= '0;
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_ready[l] <= '0;
            end
            r_run_id     <= '0;
            r_run_v      <= 1'b0;
            r_tick       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slice_base <= n_slice_base;
            r_period     <= n_period;
            r_in_use     <= n_in_use;
            r_ready      <= n_ready;
            r_run_id     <= n_run_id;
            r_run_v      <= n_run_v;
            r_tick       <= n_tick;
            r_done       <= n_done;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_lv      <= n_lv;
        r_wait    <= n_wait;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_bit     <= n_bit;
        r_reclaim <= n_reclaim;
        r_resched <= n_resched;
        r_best_id <= n_best_id;
        r_best_lv <= n_best_lv;
        r_best_v  <= n_best_v;
        r_status  <= n_status;
        r_rid     <= n_rid;
        r_rvalid  <= n_rvalid;
        r_resch_o <= n_resch_o;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_id    = r_rid;
    assign o_result_valid = r_rvalid;
    assign o_reschedule   = r_resch_o;

    // checks: running task never sits in a ready set, ready implies in use
    logic run_in_ready;
    logic ready_orphan;
    always_comb begin
        run_in_ready = 1'b0;
        ready_orphan = 1'b0;
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            run_in_ready = run_in_ready | r_ready[l][r_run_id];
            ready_orphan = ready_orphan | (|(r_ready[l] & ~r_in_use));
        end
    end

    `AM_IMPLY(a_run_not_ready, r_run_v, !run_in_ready)
    `AM_IMPLY(a_ready_in_use, 1'b1, !ready_orphan)
    `AM_NEXT(a_accept_works, start && !busy, busy || o_done)
    `AM_IMPLY(a_result_shape, o_done && o_result_valid, o_status == ST_DONE)
endmodule
`default_nettype wire
